>>> design/compact_index_varint_codec_defines.svh
// Assertion macros shared by the compact index varint codec RTL.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef COMPACT_INDEX_VARINT_CODEC_DEFINES_SVH
`define COMPACT_INDEX_VARINT_CODEC_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CIVC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CIVC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/civc_pkg.sv
// Package of the compact index varint codec: codes, sizes and the result
// structs passed between the encoder, the decoder and the top level.
package civc_pkg;

    localparam int unsigned ENC_MAX_BYTES = 5;
    localparam int unsigned CNT_W         = 3;
    localparam int unsigned POS_W         = 3;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    typedef enum logic {
        KIND_BYTE  = 1'b0,
        KIND_VALUE = 1'b1
    } t_kind;

    // Decoder byte positions within one code.
    localparam logic [POS_W-1:0] POS_FIRST  = 3'd0;
    localparam logic [POS_W-1:0] POS_SECOND = 3'd1;
    localparam logic [POS_W-1:0] POS_THIRD  = 3'd2;
    localparam logic [POS_W-1:0] POS_FOURTH = 3'd3;

    typedef struct packed {
        logic [CNT_W-1:0]                 count;
        logic [ENC_MAX_BYTES-1:0][7:0]    bytes;
    } t_enc_res;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } t_dec_res;

endpackage

>>> design/compact_index_varint_codec.sv
// Channel   Dir  tdata (low bit first)             tuser     tlast
// s_axis    in   value_in[31:0], byte_in[39:32]    op        -
// m_axis    out  byte_out[7:0], value_out[39:8]    kind      last
//
// An item is registered on input, then converted in one pass into the result
// register. An encode of n bytes holds the result register for n words, one
// word per cycle while m_axis_tready is high, shifted by the single output
// byte shifter. The next item is converted as the final word is accepted.
// Reset is synchronous, active low, and clears the decode state.
// Stalls on m_axis back up through s_axis_tready without losing words.
// Top level of the compact index varint codec; uses civc_pkg, civc_encoder,
// civc_decoder and compact_index_varint_codec_defines.svh.
`include "compact_index_varint_codec_defines.svh"

module compact_index_varint_codec import civc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value_in[31:0], byte_in[39:32]
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // byte_out[7:0], value_out[39:8]
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last
);

    logic                          r_in_valid;
    t_op                           r_in_op;
    logic signed [31:0]            r_in_value;
    logic [7:0]                    r_in_byte;

    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [ENC_MAX_BYTES-1:0][7:0] r_bytes;
    t_kind                         r_kind;
    logic [31:0]                   r_value;

    t_enc_res enc_res;
    t_dec_res dec_res;
    logic     out_take;
    logic     out_free;
    logic     adv;

    assign out_take = (r_cnt != '0) && m_axis_tready;
    assign out_free = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && m_axis_tready);
    assign adv      = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || adv;

    civc_encoder u_enc (
        .i_value (r_in_value),
        .o_res   (enc_res)
    );

    civc_decoder u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && (r_in_op == OP_DECODE)),
        .i_byte  (r_in_byte),
        .o_res   (dec_res)
    );

    always_comb begin
        n_cnt = r_cnt;
        if (adv) begin
            if (r_in_op == OP_ENCODE) begin
                n_cnt = enc_res.count;
            end else begin
                n_cnt = dec_res.done ? CNT_W'(1) : CNT_W'(0);
            end
        end else if (out_take) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op    <= t_op'(s_axis_tuser);
            r_in_value <= $signed(s_axis_tdata[31:0]);
            r_in_byte  <= s_axis_tdata[39:32];
        end
        if (adv) begin
            if (r_in_op == OP_ENCODE) begin
                r_bytes <= enc_res.bytes;
                r_kind  <= KIND_BYTE;
                r_value <= '0;
            end else begin
                r_bytes <= '0;
                r_kind  <= KIND_VALUE;
                r_value <= dec_res.value;
            end
        end else if (out_take) begin
            r_bytes <= {8'h00, r_bytes[ENC_MAX_BYTES-1:1]};
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {r_value, r_bytes[0]};
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = (r_cnt == CNT_W'(1));

    `CIVC_ASSERT_IMP(a_cnt_range, 1'b1, r_cnt <= CNT_W'(ENC_MAX_BYTES), "word count out of range")
    `CIVC_ASSERT_IMP(a_value_single, m_axis_tvalid && (m_axis_tuser == KIND_VALUE), m_axis_tlast, "decoded value not marked last")
    `CIVC_ASSERT_NXT(a_enc_emits, adv && (r_in_op == OP_ENCODE), r_cnt != '0, "encode produced no byte")
    `CIVC_ASSERT_NXT(a_drain_step, out_take && (r_cnt > CNT_W'(1)), r_cnt == ($past(r_cnt) - CNT_W'(1)), "burst count did not step down")

endmodule

>>> design/civc_encoder.sv
// Combinational encoder: splits the magnitude of a signed 32-bit value into
// one to five code bytes. Depends on civc_pkg.
module civc_encoder import civc_pkg::*; (
    input  logic signed [31:0] i_value,
    output t_enc_res           o_res
);

    logic        neg;
    logic [31:0] mag;
    logic [CNT_W-1:0] cnt;

    always_comb begin
        neg = i_value[31];
        // The most negative value wraps to a magnitude of 2^31.
        mag = neg ? (32'd0 - $unsigned(i_value)) : $unsigned(i_value);

        if (mag[31:6] == '0) begin
            cnt = CNT_W'(1);
        end else if (mag[31:13] == '0) begin
            cnt = CNT_W'(2);
        end else if (mag[31:20] == '0) begin
            cnt = CNT_W'(3);
        end else if (mag[31:27] == '0) begin
            cnt = CNT_W'(4);
        end else begin
            cnt = CNT_W'(5);
        end

        o_res.count    = cnt;
        o_res.bytes[0] = {neg, (cnt > CNT_W'(1)), mag[5:0]};
        o_res.bytes[1] = {(cnt > CNT_W'(2)), mag[12:6]};
        o_res.bytes[2] = {(cnt > CNT_W'(3)), mag[19:13]};
        o_res.bytes[3] = {(cnt > CNT_W'(4)), mag[26:20]};
        o_res.bytes[4] = {3'b000, mag[31:27]};
    end

endmodule

>>> design/civc_decoder.sv
// Decoder state (position, accumulator, sign) and the per-byte merge logic.
// Depends on civc_pkg.
module civc_decoder import civc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [7:0] i_byte,
    output t_dec_res   o_res
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_acc, n_acc;
    logic             r_neg, n_neg;
    logic             done;

    always_comb begin
        n_neg = r_neg;
        case (r_pos)
            POS_FIRST: begin
                n_neg = i_byte[7];
                n_acc = {26'd0, i_byte[5:0]};
                done  = !i_byte[6];
            end
            POS_SECOND: begin
                n_acc = r_acc | {19'd0, i_byte[6:0], 6'd0};
                done  = !i_byte[7];
            end
            POS_THIRD: begin
                n_acc = r_acc | {12'd0, i_byte[6:0], 13'd0};
                done  = !i_byte[7];
            end
            POS_FOURTH: begin
                n_acc = r_acc | {5'd0, i_byte[6:0], 20'd0};
                done  = !i_byte[7];
            end
            default: begin
                // Bit 5 of the last byte would land in bit 32 and is dropped.
                n_acc = r_acc | {i_byte[4:0], 27'd0};
                done  = 1'b1;
            end
        endcase
        n_pos = done ? POS_FIRST : (r_pos + POS_W'(1));

        o_res.done  = done;
        o_res.value = n_neg ? (32'd0 - n_acc) : n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_FIRST;
            r_acc <= '0;
            r_neg <= 1'b0;
        end else if (i_load) begin
            r_pos <= n_pos;
            r_acc <= n_acc;
            r_neg <= n_neg;
        end
    end

endmodule

>>> tb/compact_index_varint_codec_check.sv
// Result checker for the compact index varint codec: predicts encoded bytes and
// decoded values from the accepted s_axis words and compares every m_axis word.
// Depends on civc_pkg for the operation and result kind codes.
`timescale 1ns / 1ps

module compact_index_varint_codec_check import civc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // value_in[31:0], byte_in[39:32]
    input  logic        i_s_axis_tuser,   // op
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [39:0] i_m_axis_tdata,   // byte_out[7:0], value_out[39:8]
    input  logic        i_m_axis_tuser,   // kind
    input  logic        i_m_axis_tlast,   // last
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  code_byte;
        logic [31:0] value;
        logic        last;
    } t_word;

    t_word       codec_words_q[$];
    logic [2:0]  dec_pos;
    logic [31:0] dec_mag;
    logic        dec_neg;
    int          mismatches = 0;

    function automatic void add_word(t_kind kind, logic [7:0] code_byte,
                                     logic [31:0] value, logic last);
        t_word w;
        w.kind      = kind;
        w.code_byte = code_byte;
        w.value     = value;
        w.last      = last;
        codec_words_q.push_back(w);
    endfunction

    // Sign and magnitude; the most negative value wraps to a magnitude of 2^31.
    function automatic void encode_value(logic [31:0] raw);
        logic        neg;
        logic [31:0] mag;
        logic        ended;
        neg   = raw[31];
        mag   = neg ? 32'(-raw) : raw;
        ended = 1'b0;
        if (mag <= 32'h3F) begin
            add_word(KIND_BYTE, {neg, 1'b0, mag[5:0]}, 32'd0, 1'b1);
        end else begin
            add_word(KIND_BYTE, {neg, 1'b1, mag[5:0]}, 32'd0, 1'b0);
            mag = mag >> 6;
            for (int i = 0; i < 3; i++) begin
                if (!ended) begin
                    if (mag <= 32'h7F) begin
                        add_word(KIND_BYTE, {1'b0, mag[6:0]}, 32'd0, 1'b1);
                        ended = 1'b1;
                    end else begin
                        add_word(KIND_BYTE, {1'b1, mag[6:0]}, 32'd0, 1'b0);
                        mag = mag >> 7;
                    end
                end
            end
            if (!ended)
                add_word(KIND_BYTE, {2'b00, mag[5:0]}, 32'd0, 1'b1);
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        logic ends;
        case (dec_pos)
            POS_FIRST: begin
                dec_neg = b[7];
                dec_mag = {26'd0, b[5:0]};
                ends    = !b[6];
            end
            POS_SECOND: begin
                dec_mag = dec_mag | ({25'd0, b[6:0]} << 6);
                ends    = !b[7];
            end
            POS_THIRD: begin
                dec_mag = dec_mag | ({25'd0, b[6:0]} << 13);
                ends    = !b[7];
            end
            POS_FOURTH: begin
                dec_mag = dec_mag | ({25'd0, b[6:0]} << 20);
                ends    = !b[7];
            end
            default: begin
                // Fifth byte: bit 5 would land in bit 32 and falls away.
                dec_mag = dec_mag | {b[4:0], 27'd0};
                ends    = 1'b1;
            end
        endcase
        if (!ends) begin
            dec_pos = dec_pos + 3'd1;
        end else begin
            add_word(KIND_VALUE, 8'd0, dec_neg ? 32'(-dec_mag) : dec_mag, 1'b1);
            dec_pos = POS_FIRST;
        end
    endfunction

    function automatic void note_mismatch(string what, t_word exp_w, t_word act_w);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected kind %0d byte %h value %h last %0d, %s%0d%s%h%s%h%s%0d",
                     $time, what, exp_w.kind, exp_w.code_byte, exp_w.value, exp_w.last,
                     "got kind ", act_w.kind, " byte ", act_w.code_byte,
                     " value ", act_w.value, " last ", act_w.last);
    endfunction

    always @(posedge i_clk) begin
        t_word act_w;
        t_word exp_w;
        if (!i_rst_n) begin
            dec_pos = POS_FIRST;
            dec_mag = 32'd0;
            dec_neg = 1'b0;
            codec_words_q.delete();
        end else begin
            // The block registers its input, so a word accepted here cannot
            // be answered in this same cycle; predicting first is safe.
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (t_op'(i_s_axis_tuser) == OP_ENCODE)
                    encode_value(i_s_axis_tdata[31:0]);
                else
                    decode_byte(i_s_axis_tdata[39:32]);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                act_w.kind      = t_kind'(i_m_axis_tuser);
                act_w.code_byte = i_m_axis_tdata[7:0];
                act_w.value     = i_m_axis_tdata[39:8];
                act_w.last      = i_m_axis_tlast;
                if (codec_words_q.size() == 0) begin
                    exp_w = '0;
                    note_mismatch("unexpected word", exp_w, act_w);
                end else begin
                    exp_w = codec_words_q.pop_front();
                    if (act_w.kind !== exp_w.kind || act_w.code_byte !== exp_w.code_byte ||
                        act_w.value !== exp_w.value || act_w.last !== exp_w.last)
                        note_mismatch("word mismatch", exp_w, act_w);
                end
            end
        end
        o_pending    <= codec_words_q.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> tb/compact_index_varint_codec_test.sv
// Top of the compact index varint codec testbench: clock, reset, stimulus with
// idle and stall phases, watchdog and verdict. Uses civc_pkg and the result checker.
`timescale 1ns / 1ps

module compact_index_varint_codec_test import civc_pkg::*;;

    localparam int RANDOM_ITEMS = 235;
    localparam int STALL_LIMIT  = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // value_in[31:0], byte_in[39:32]
    logic        s_axis_tuser = 1'b0; // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // byte_out[7:0], value_out[39:8]
    logic        m_axis_tuser;        // kind
    logic        m_axis_tlast;        // last

    int fail_count;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    compact_index_varint_codec uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    compact_index_varint_codec_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // The unused field of every word carries random bits as well.
    task automatic send_word(t_op op, logic [31:0] value, logic [7:0] code_byte);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {code_byte, value};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_encode(logic [31:0] value);
        send_word(OP_ENCODE, value, 8'($urandom));
    endtask

    task automatic send_decode(logic [7:0] code_byte);
        send_word(OP_DECODE, $urandom, code_byte);
    endtask

    // A well-formed code of the given length with random content; encode words
    // sometimes fall between its bytes, which must not disturb the decoder.
    task automatic send_code(int nbytes);
        logic [7:0] b;
        for (int k = 0; k < nbytes; k++) begin
            b = 8'($urandom);
            if (k == 0)
                b[6] = (nbytes > 1);
            else if (k < 4)
                b[7] = (k < nbytes - 1);
            send_decode(b);
            if (k < nbytes - 1 && $urandom_range(99) < 15)
                send_encode($urandom);
        end
    endtask

    function automatic logic [31:0] spread_value();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(9) != 0)
            v = $signed(v) >>> $urandom_range(31);
        return v;
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Length boundaries of the encoding, both signs and the extremes.
        send_encode(32'd0);
        send_encode(32'd63);
        send_encode(32'd64);
        send_encode(-32'sd1);
        send_encode(-32'sd63);
        send_encode(-32'sd64);
        send_encode(32'h0000_1FFF);
        send_encode(32'h0000_2000);
        send_encode(32'h000F_FFFF);
        send_encode(32'h0010_0000);
        send_encode(32'h07FF_FFFF);
        send_encode(32'h0800_0000);
        send_encode(32'h7FFF_FFFF);
        send_encode(32'h8000_0000);
        // Negative zero, then the largest one-byte code.
        send_decode(8'h80);
        send_decode(8'h3F);
        // Five bytes with every bit set: the top bits of the fifth are dropped.
        repeat (5) send_decode(8'hFF);
        // A code split by an encode, ending on a zero byte.
        send_decode(8'h40);
        send_decode(8'h81);
        send_encode(32'd5);
        send_decode(8'h00);

        while (items_sent < RANDOM_ITEMS + 25) begin
            case ((items_sent - 25) * 4 / RANDOM_ITEMS)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3: send_encode(spread_value());
                4:          send_decode(8'($urandom));
                default:    send_code($urandom_range(1, 5));
            endcase
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/civc_pkg.sv
design/civc_encoder.sv
design/civc_decoder.sv
design/compact_index_varint_codec.sv
tb/compact_index_varint_codec_check.sv
tb/compact_index_varint_codec_test.sv
